/* rtl/core/sfp_pkg.sv */
// Shared types and constants of the sensor frame parser.
`timescale 1ns / 1ps
`default_nettype none

package sfp_pkg;

    localparam int FRAME_BYTES = 32;
    localparam int POS_W       = $clog2(FRAME_BYTES);

    localparam logic [7:0]       HDR_FIRST     = 8'h42;
    localparam logic [7:0]       HDR_SECOND    = 8'h4D;
    localparam logic [15:0]      LEN_RESET     = 16'h001C;
    localparam logic [POS_W-1:0] POS_HDR0      = 5'd0;
    localparam logic [POS_W-1:0] POS_HDR1      = 5'd1;
    localparam logic [POS_W-1:0] POS_HDR2      = 5'd2;
    localparam logic [POS_W-1:0] POS_LEN_HI    = 5'd2;
    localparam logic [POS_W-1:0] POS_LEN_LO    = 5'd3;
    localparam logic [POS_W-1:0] POS_DATA_BASE = 5'd4;
    localparam logic [POS_W-1:0] SUM_BYTES     = 5'd30;
    localparam logic [POS_W-1:0] POS_CHK_HI    = 5'd30;
    localparam logic [POS_W-1:0] POS_CHK_LO    = 5'd31;
    localparam logic [3:0]       LAST_WORD_IDX = 4'd12;

    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;
    localparam logic REG_EXP_LEN = 1'b0;

    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef logic alu_op_t;

    typedef struct packed {
        alu_op_t     op;
        logic [15:0] a;
        logic [15:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [15:0] res;
        logic        zero;
    } alu_rsp_t;

    typedef struct packed {
        logic             we;
        logic             re;
        logic [POS_W-1:0] addr;
        logic [7:0]       wdata;
    } mem_req_t;

endpackage

`default_nettype wire

/* rtl/core/sensor_frame_parser_unit.sv */
// Top level of the sensor frame parser: register port and core wiring.
//
//   port group   dir   beat contents
//   s_*          in    one received serial byte
//   m_*          out   one data word of a checked frame, tlast on word 12
//   APB          in    expected_length register at byte address 0
//
// Each byte is first taken from the beat, then stored and added to the running
// checksum in the shared adder. After the 32nd byte the same adder compares the
// length and then the checksum (the checksum compare is skipped when the length
// fails). Each data word then takes two frame store reads, a load and a present,
// plus any m_tready stall; s_tready stays low until the last word is taken. Reset
// clears the sequencer and position, and sets expected_length to 28.
`timescale 1ns / 1ps
`default_nettype none

module sensor_frame_parser_unit
    import sfp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // [7:0] rx_byte
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [23:0]             m_tdata,   // [3:0] word_index, [19:4] word_value
    output logic                    m_tlast,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);

    logic [15:0] exp_len_reg, exp_len_next;
    logic        reg_hit;
    mem_req_t    mem_req;
    logic [7:0]  mem_rdata;
    alu_req_t    alu_req;
    alu_rsp_t    alu_rsp;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1] == REG_EXP_LEN) && (paddr[1:0] == 2'd0);

    always_comb
    begin
        exp_len_next = exp_len_reg;
        if (psel && penable && pwrite && pready && reg_hit)
        begin
            exp_len_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_len_reg <= LEN_RESET;
        end
        else
        begin
            exp_len_reg <= exp_len_next;
        end
    end

    assign prdata = reg_hit ? {16'd0, exp_len_reg} : '0;

    sfp_seq u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .expected_length (exp_len_reg),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .mem_req         (mem_req),
        .mem_rdata       (mem_rdata),
        .alu_req         (alu_req),
        .alu_rsp         (alu_rsp)
    );

    sfp_fmem u_fmem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    sfp_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

endmodule

`default_nettype wire

/* rtl/core/sfp_alu.sv */
// Shared 16-bit add/subtract unit with zero flag.
`timescale 1ns / 1ps
`default_nettype none

module sfp_alu
    import sfp_pkg::*;
(
    input  wire alu_req_t req,
    output alu_rsp_t      rsp
);

    logic [15:0] b_op;
    logic [15:0] sum;

    assign b_op = (req.op == ALU_SUB) ? ~req.b : req.b;
    assign sum  = req.a + b_op + {15'd0, (req.op == ALU_SUB)};

    assign rsp.res  = sum;
    assign rsp.zero = (sum == 16'd0);

endmodule

`default_nettype wire

/* rtl/core/sfp_fmem.sv */
// Frame byte store with one write and one registered read.
`timescale 1ns / 1ps
`default_nettype none

module sfp_fmem
    import sfp_pkg::*;
(
    input  wire logic       clk,
    input  wire mem_req_t   req,
    output logic [7:0]      rdata
);

    logic [7:0] frame_mem_reg [FRAME_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            frame_mem_reg[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= frame_mem_reg[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/core/sfp_seq.sv */
// Sequencer: header hunt, byte collection, frame checks and word output.
`timescale 1ns / 1ps
`default_nettype none

module sfp_seq
    import sfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [15:0] expected_length,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,
    output logic             m_tlast,
    output mem_req_t         mem_req,
    input  wire logic [7:0]  mem_rdata,
    output alu_req_t         alu_req,
    input  wire alu_rsp_t    alu_rsp
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_PROC    = 3'd1;
    localparam logic [2:0] ST_CHKLEN  = 3'd2;
    localparam logic [2:0] ST_CHKSUM  = 3'd3;
    localparam logic [2:0] ST_RDHI    = 3'd4;
    localparam logic [2:0] ST_RDLO    = 3'd5;
    localparam logic [2:0] ST_LOAD    = 3'd6;
    localparam logic [2:0] ST_SEND    = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [3:0]       widx_reg, widx_next;
    logic             m_tvalid_reg, m_tvalid_next;

    logic [7:0]  byte_reg, byte_next;
    logic [15:0] sum_reg, sum_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] chk_reg, chk_next;
    logic [7:0]  hi_reg, hi_next;
    logic [3:0]  out_idx_reg, out_idx_next;
    logic [15:0] out_val_reg, out_val_next;
    logic        out_last_reg, out_last_next;

    logic [POS_W-1:0] word_addr;

    assign word_addr = POS_DATA_BASE + {widx_reg, 1'b0};

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        widx_next     = widx_reg;
        m_tvalid_next = m_tvalid_reg;
        byte_next     = byte_reg;
        sum_next      = sum_reg;
        len_next      = len_reg;
        chk_next      = chk_reg;
        hi_next       = hi_reg;
        out_idx_next  = out_idx_reg;
        out_val_next  = out_val_reg;
        out_last_next = out_last_reg;

        mem_req.we    = 1'b0;
        mem_req.re    = 1'b0;
        mem_req.addr  = pos_reg;
        mem_req.wdata = byte_reg;

        alu_req.op = ALU_ADD;
        alu_req.a  = sum_reg;
        alu_req.b  = {8'd0, byte_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    byte_next  = s_tdata;
                    state_next = ST_PROC;
                end
            end
            ST_PROC:
            begin
                mem_req.we = 1'b1;
                state_next = ST_IDLE;
                if (pos_reg == POS_HDR0)
                begin
                    sum_next = {8'd0, byte_reg};
                    pos_next = (byte_reg == HDR_FIRST) ? POS_HDR1 : POS_HDR0;
                end
                else if (pos_reg == POS_HDR1)
                begin
                    if (byte_reg == HDR_SECOND)
                    begin
                        sum_next = alu_rsp.res;
                        pos_next = POS_HDR2;
                    end
                    else if (byte_reg == HDR_FIRST)
                    begin
                        pos_next = POS_HDR1;
                    end
                    else
                    begin
                        pos_next = POS_HDR0;
                    end
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                    if (pos_reg < SUM_BYTES)
                    begin
                        sum_next = alu_rsp.res;
                    end
                    if (pos_reg == POS_LEN_HI)
                    begin
                        len_next[15:8] = byte_reg;
                    end
                    if (pos_reg == POS_LEN_LO)
                    begin
                        len_next[7:0] = byte_reg;
                    end
                    if (pos_reg == POS_CHK_HI)
                    begin
                        chk_next[15:8] = byte_reg;
                    end
                    if (pos_reg == POS_CHK_LO)
                    begin
                        chk_next[7:0] = byte_reg;
                        state_next    = ST_CHKLEN;
                    end
                end
            end
            ST_CHKLEN:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = len_reg;
                alu_req.b  = expected_length;
                state_next = alu_rsp.zero ? ST_CHKSUM : ST_IDLE;
            end
            ST_CHKSUM:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = chk_reg;
                alu_req.b  = sum_reg;
                widx_next  = 4'd0;
                state_next = alu_rsp.zero ? ST_RDHI : ST_IDLE;
            end
            ST_RDHI:
            begin
                mem_req.re   = 1'b1;
                mem_req.addr = word_addr;
                state_next   = ST_RDLO;
            end
            ST_RDLO:
            begin
                mem_req.re   = 1'b1;
                mem_req.addr = word_addr | {{(POS_W-1){1'b0}}, 1'b1};
                hi_next      = mem_rdata;
                state_next   = ST_LOAD;
            end
            ST_LOAD:
            begin
                out_val_next  = {hi_reg, mem_rdata};
                out_idx_next  = widx_reg;
                out_last_next = (widx_reg == LAST_WORD_IDX);
                m_tvalid_next = 1'b1;
                state_next    = ST_SEND;
            end
            ST_SEND:
            begin
                if (m_tready)
                begin
                    m_tvalid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        widx_next  = widx_reg + 1'b1;
                        state_next = ST_RDHI;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pos_reg      <= POS_HDR0;
            widx_reg     <= 4'd0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            widx_reg     <= widx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        sum_reg      <= sum_next;
        len_reg      <= len_next;
        chk_reg      <= chk_next;
        hi_reg       <= hi_next;
        out_idx_reg  <= out_idx_next;
        out_val_reg  <= out_val_next;
        out_last_reg <= out_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, out_val_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

/* rtl/core/sfp_checker.sv */
// Port-level checks of the sensor frame parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sfp_checker
    import sfp_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic        m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a word is pending");

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted byte");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[3:0] == LAST_WORD_IDX)))
        else $error("tlast does not match the final word index");

endmodule

bind sensor_frame_parser_unit sfp_checker u_sfp_checker (.*);

`default_nettype wire
